### hw/rtl/owfe_pkg.sv
// Shared constants and types for the omni wheel speed frame encoder.
`timescale 1ns / 1ps

package owfe_pkg;

  localparam int NUM_WHEELS     = 4;
  localparam int WHEEL_IDX_W    = $clog2(NUM_WHEELS);
  localparam int COEF_FRAC_BITS = 28;
  localparam int SPIN_FRAC_BITS = 24;
  localparam int SUM_FRAC_BITS  = 30;
  localparam int COEF_SHIFT     = SUM_FRAC_BITS - COEF_FRAC_BITS;
  localparam int SPIN_SHIFT     = SUM_FRAC_BITS - SPIN_FRAC_BITS;

  localparam int VEL_W   = 16;
  localparam int COEF_W  = 32;
  localparam int REG_W   = 2 * COEF_W;
  localparam int PROD_W  = COEF_W + VEL_W;
  localparam int ACC_W   = 64;
  localparam int QUOT_W  = ACC_W - SUM_FRAC_BITS;
  localparam int SPEED_W = 16;

  localparam int FRAME_LEN = 10;
  localparam int BYTE_IDX_W = $clog2(FRAME_LEN);
  localparam logic [7:0] FRAME_HEADER = 8'hFF;
  localparam logic [7:0] FRAME_FOOTER = 8'hAA;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_GAIN = 3'd4;

  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic [REG_W-1:0]          wheel_reg_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

endpackage

### hw/rtl/owfe_mul_stage.sv
// First stage: the per-wheel x and y products and the shared spin product.
`timescale 1ns / 1ps

module owfe_mul_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  owfe_pkg::vel_t         vel_x,
  input  owfe_pkg::vel_t         vel_y,
  input  owfe_pkg::vel_t         omega,
  input  owfe_pkg::wheel_reg_t   wheel_coeffs [owfe_pkg::NUM_WHEELS],
  input  owfe_pkg::coef_t        spin_gain,
  output logic                   out_valid,
  input  logic                   out_ready,
  output owfe_pkg::prod_t        prod_x [owfe_pkg::NUM_WHEELS],
  output owfe_pkg::prod_t        prod_y [owfe_pkg::NUM_WHEELS],
  output owfe_pkg::prod_t        prod_spin
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int w = 0; w < owfe_pkg::NUM_WHEELS; w++) begin
        prod_x[w] <= owfe_pkg::coef_t'(wheel_coeffs[w][owfe_pkg::REG_W-1:owfe_pkg::COEF_W])
                     * vel_x;
        prod_y[w] <= owfe_pkg::coef_t'(wheel_coeffs[w][owfe_pkg::COEF_W-1:0]) * vel_y;
      end
      prod_spin <= spin_gain * omega;
    end
  end

endmodule

### hw/rtl/owfe_sum_stage.sv
// Second stage: align the three products to a common fraction and add them.
`timescale 1ns / 1ps

module owfe_sum_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  owfe_pkg::prod_t    prod_x [owfe_pkg::NUM_WHEELS],
  input  owfe_pkg::prod_t    prod_y [owfe_pkg::NUM_WHEELS],
  input  owfe_pkg::prod_t    prod_spin,
  output logic               out_valid,
  input  logic               out_ready,
  output owfe_pkg::acc_t     acc [owfe_pkg::NUM_WHEELS]
);

  owfe_pkg::acc_t spin_term;

  assign in_ready  = !out_valid || out_ready;
  assign spin_term = owfe_pkg::acc_t'(prod_spin) <<< owfe_pkg::SPIN_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int w = 0; w < owfe_pkg::NUM_WHEELS; w++) begin
        acc[w] <= (owfe_pkg::acc_t'(prod_x[w]) <<< owfe_pkg::COEF_SHIFT)
                + (owfe_pkg::acc_t'(prod_y[w]) <<< owfe_pkg::COEF_SHIFT)
                + spin_term;
      end
    end
  end

endmodule

### hw/rtl/owfe_sat_stage.sv
// Third stage: drop the fraction toward zero and clamp each speed to 16 bits.
`timescale 1ns / 1ps

module owfe_sat_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  owfe_pkg::acc_t     acc [owfe_pkg::NUM_WHEELS],
  output logic               out_valid,
  input  logic               out_ready,
  output owfe_pkg::speed_t   speed [owfe_pkg::NUM_WHEELS]
);

  localparam int QW = owfe_pkg::QUOT_W;
  localparam logic signed [QW-1:0] Q_MAX = (QW'(1) <<< (owfe_pkg::SPEED_W - 1)) - QW'(1);
  localparam logic signed [QW-1:0] Q_MIN = -(QW'(1) <<< (owfe_pkg::SPEED_W - 1));

  logic signed [QW-1:0]  quot [owfe_pkg::NUM_WHEELS];
  owfe_pkg::speed_t      speed_next [owfe_pkg::NUM_WHEELS];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int w = 0; w < owfe_pkg::NUM_WHEELS; w++) begin
      quot[w] = QW'(acc[w] >>> owfe_pkg::SUM_FRAC_BITS);
      // floor to truncation: bump negatives that had fraction bits
      if (acc[w][owfe_pkg::ACC_W-1] && (acc[w][owfe_pkg::SUM_FRAC_BITS-1:0] != '0)) begin
        quot[w] = quot[w] + QW'(1);
      end
      if (quot[w] > Q_MAX) begin
        speed_next[w] = owfe_pkg::speed_t'(Q_MAX);
      end else if (quot[w] < Q_MIN) begin
        speed_next[w] = owfe_pkg::speed_t'(Q_MIN);
      end else begin
        speed_next[w] = owfe_pkg::speed_t'(quot[w]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      speed <= speed_next;
    end
  end

endmodule

### hw/rtl/owfe_frame.sv
// Frame serialiser: header, four speeds high byte first, footer.
`timescale 1ns / 1ps

module owfe_frame (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  owfe_pkg::speed_t                  speed_in [owfe_pkg::NUM_WHEELS],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        frame_byte,
  output logic                              frame_last
);

  localparam logic [owfe_pkg::BYTE_IDX_W-1:0] LAST_IDX =
    owfe_pkg::BYTE_IDX_W'(owfe_pkg::FRAME_LEN - 1);

  owfe_pkg::speed_t                  speed [owfe_pkg::NUM_WHEELS];
  logic [owfe_pkg::BYTE_IDX_W-1:0]   byte_idx;
  logic [owfe_pkg::BYTE_IDX_W-1:0]   body_idx;
  logic [owfe_pkg::SPEED_W-1:0]      cur_speed;

  assign frame_last = (byte_idx == LAST_IDX);
  assign in_ready   = !out_valid || (out_ready && frame_last);
  assign body_idx   = byte_idx - owfe_pkg::BYTE_IDX_W'(1);
  assign cur_speed  = speed[body_idx[owfe_pkg::WHEEL_IDX_W:1]];

  always_comb begin
    if (byte_idx == '0) begin
      frame_byte = owfe_pkg::FRAME_HEADER;
    end else if (frame_last) begin
      frame_byte = owfe_pkg::FRAME_FOOTER;
    end else if (!body_idx[0]) begin
      frame_byte = cur_speed[owfe_pkg::SPEED_W-1:8];
    end else begin
      frame_byte = cur_speed[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else if (in_ready) begin
      // load the next item, or go idle once the footer has left
      out_valid <= in_valid;
      byte_idx  <= '0;
    end else if (out_ready) begin
      byte_idx <= byte_idx + owfe_pkg::BYTE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      speed <= speed_in;
    end
  end

endmodule

### hw/rtl/omni_wheel_speed_frame_encoder.sv
// Top level: configuration registers, the arithmetic pipeline and the frame serialiser.
`timescale 1ns / 1ps

// Each velocity command becomes four wheel speeds (kx*vx + ky*vy + spin_gain*omega,
// truncated toward zero and clamped to int16) sent as a ten-byte frame: 0xFF, the
// speeds high byte first, 0xAA, one byte per cycle while out_ready is high, with
// frame_last on the footer. The arithmetic runs through three register stages
// (products, aligned sum, truncate and clamp); a command's first byte leaves once it
// has passed all three and been loaded into the byte serialiser, which sets the
// sustained throughput; the pipeline holds up to three further commands meanwhile.
// Coefficient registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no command is in flight.

module omni_wheel_speed_frame_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [owfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owfe_pkg::REG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                vel_x_mm,
  input  logic signed [15:0]                vel_y_mm,
  input  logic signed [15:0]                angular_rate,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        frame_byte,
  output logic                              frame_last
);

  owfe_pkg::wheel_reg_t  wheel_coeffs [owfe_pkg::NUM_WHEELS];
  owfe_pkg::coef_t       spin_gain;

  logic                  mul_valid, mul_ready;
  owfe_pkg::prod_t       prod_x [owfe_pkg::NUM_WHEELS];
  owfe_pkg::prod_t       prod_y [owfe_pkg::NUM_WHEELS];
  owfe_pkg::prod_t       prod_spin;
  logic                  sum_valid, sum_ready;
  owfe_pkg::acc_t        acc [owfe_pkg::NUM_WHEELS];
  logic                  sat_valid, sat_ready;
  owfe_pkg::speed_t      speed [owfe_pkg::NUM_WHEELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < owfe_pkg::NUM_WHEELS; w++) begin
        wheel_coeffs[w] <= '0;
      end
      spin_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        owfe_pkg::REG_WHEEL0:    wheel_coeffs[0] <= cfg_data;
        owfe_pkg::REG_WHEEL1:    wheel_coeffs[1] <= cfg_data;
        owfe_pkg::REG_WHEEL2:    wheel_coeffs[2] <= cfg_data;
        owfe_pkg::REG_WHEEL3:    wheel_coeffs[3] <= cfg_data;
        owfe_pkg::REG_SPIN_GAIN: spin_gain <= owfe_pkg::coef_t'(cfg_data[owfe_pkg::COEF_W-1:0]);
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  owfe_mul_stage u_mul (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vel_x        (vel_x_mm),
    .vel_y        (vel_y_mm),
    .omega        (angular_rate),
    .wheel_coeffs (wheel_coeffs),
    .spin_gain    (spin_gain),
    .out_valid    (mul_valid),
    .out_ready    (mul_ready),
    .prod_x       (prod_x),
    .prod_y       (prod_y),
    .prod_spin    (prod_spin)
  );

  owfe_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .prod_x    (prod_x),
    .prod_y    (prod_y),
    .prod_spin (prod_spin),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .acc       (acc)
  );

  owfe_sat_stage u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .acc       (acc),
    .out_valid (sat_valid),
    .out_ready (sat_ready),
    .speed     (speed)
  );

  owfe_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sat_valid),
    .in_ready   (sat_ready),
    .speed_in   (speed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
  );

`ifndef ASSERT_OFF
  a_last_is_footer: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> frame_byte == owfe_pkg::FRAME_FOOTER)
    else $error("frame_last raised on a byte other than the footer");

  a_header_follows_footer: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_last |=> !out_valid || frame_byte == owfe_pkg::FRAME_HEADER)
    else $error("new frame does not open with the header byte");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule

### dv/tb_omni_wheel_speed_frame_encoder.sv
// Self-checking testbench for the omni wheel speed frame encoder.
`timescale 1ns / 1ps

module tb_omni_wheel_speed_frame_encoder;
  import owfe_pkg::*;

  typedef logic [NUM_WHEELS-1:0][SPEED_W-1:0] speed_set_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    wheel_reg_t w0;
    wheel_reg_t w1;
    wheel_reg_t w2;
    wheel_reg_t w3;
    coef_t      spin;
  } coeff_set_t;

  // One directed command: coefficient set, whether speeds are typed in, inputs, speeds.
  typedef struct packed {
    int cfg_set;
    int typed;
    int vx;
    int vy;
    int om;
    int s0;
    int s1;
    int s2;
    int s3;
  } cmd_row_t;

  localparam coef_t  COEF_MAX    = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t  COEF_MIN    = {1'b1, {(COEF_W-1){1'b0}}};
  localparam vel_t   VEL_MAX     = {1'b0, {(VEL_W-1){1'b1}}};
  localparam vel_t   VEL_MIN     = {1'b1, {(VEL_W-1){1'b0}}};
  localparam longint SPEED_MAX   = (longint'(1) <<< (SPEED_W - 1)) - 1;
  localparam longint SPEED_MIN   = -SPEED_MAX - 1;
  localparam int     RAND_PHASES = 7;
  localparam int     PHASE_ITEMS = 52;
  localparam int     NUM_SETS    = 5;
  localparam int     NUM_ROWS    = 22;

  // Reset values; extremes; unity gains; half-unit spin for truncation; a realistic base.
  localparam coeff_set_t DIRECTED_SETS [0:NUM_SETS-1] = '{
    '{64'h0, 64'h0, 64'h0, 64'h0, 32'h0},
    '{64'h7FFFFFFF_7FFFFFFF, 64'h80000000_80000000,
      64'h7FFFFFFF_80000000, 64'h80000000_7FFFFFFF, 32'h7FFFFFFF},
    '{64'h10000000_00000000, 64'h00000000_10000000,
      64'hF0000000_00000000, 64'h0, 32'h01000000},
    '{64'h0, 64'h00000001_00000000, 64'h0, 64'hC0000000_00000000, 32'h00800000},
    '{64'hFF9F7450_00608BB0, 64'hFF9F7450_FF9F7450,
      64'h00608BB0_FF9F7450, 64'h00608BB0_00608BB0, 32'h02AAAAAB}
  };

  localparam cmd_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 32767, -32768, 32767, 0, 0, 0, 0},
    '{1, 1, 32767, 32767, 0, 32767, -32768, 0, 0},
    '{1, 0, -32768, -32768, -32768, 0, 0, 0, 0},
    '{1, 1, 0, 0, 32767, 32767, 32767, 32767, 32767},
    '{1, 1, 0, 0, -32768, -32768, -32768, -32768, -32768},
    '{2, 1, 100, -200, 0, 100, -200, -100, 0},
    '{2, 1, -32768, 32767, 0, -32768, 32767, 32767, 0},
    '{2, 1, 0, 0, -32768, -32768, -32768, -32768, -32768},
    '{2, 1, 32767, 32767, 1, 32767, 32767, -32766, 1},
    '{2, 1, -1, 1, 0, -1, 1, 1, 0},
    '{2, 0, 12345, -4321, -77, 0, 0, 0, 0},
    '{3, 1, 0, 0, 3, 1, 1, 1, 1},
    '{3, 1, 0, 0, -3, -1, -1, -1, -1},
    '{3, 1, 8192, 0, 1, 0, 0, 0, -32767},
    '{3, 1, -8192, 0, -1, 0, 0, 0, 32767},
    '{3, 1, -8193, 0, 0, 0, 0, 0, 32767},
    '{3, 1, 8193, 0, 0, 0, 0, 0, -32768},
    '{4, 0, 1000, 0, 0, 0, 0, 0, 0},
    '{4, 0, 0, 1500, 0, 0, 0, 0, 0},
    '{4, 0, -700, 700, 12, 0, 0, 0, 0},
    '{4, 0, 2000, -1000, -3, 0, 0, 0, 0}
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  cfg_idx_t    cfg_index    = '0;
  wheel_reg_t  cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  vel_t        vel_x_mm     = '0;
  vel_t        vel_y_mm     = '0;
  vel_t        angular_rate = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  frame_byte;
  logic        frame_last;

  wheel_reg_t  wheel_coeffs [NUM_WHEELS];
  coef_t       spin_coeff;
  frame_beat_t frame_bytes_due [$];
  frame_beat_t due_beat;
  int          error_count  = 0;
  int          beats_seen   = 0;
  int          stall_left   = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  omni_wheel_speed_frame_encoder uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vel_x_mm     (vel_x_mm),
    .vel_y_mm     (vel_y_mm),
    .angular_rate (angular_rate),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_byte   (frame_byte),
    .frame_last   (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < 40) begin
      $display("ERROR at byte %0d: %s got %02h expected %02h", beats_seen, what, got, want);
    end
    error_count++;
  endtask

  // Exact sum at 30 fraction bits, truncate toward zero, clamp to int16.
  function automatic speed_set_t predict_wheel_speeds(vel_t vx, vel_t vy, vel_t om);
    speed_set_t speeds;
    coef_t      kx;
    coef_t      ky;
    longint     acc;
    longint     q;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      kx  = wheel_coeffs[w][REG_W-1:COEF_W];
      ky  = wheel_coeffs[w][COEF_W-1:0];
      acc = ((longint'(kx) * longint'(vx)) <<< COEF_SHIFT)
          + ((longint'(ky) * longint'(vy)) <<< COEF_SHIFT)
          + ((longint'(spin_coeff) * longint'(om)) <<< SPIN_SHIFT);
      q = acc / (longint'(1) <<< SUM_FRAC_BITS);
      if (q > SPEED_MAX) q = SPEED_MAX;
      if (q < SPEED_MIN) q = SPEED_MIN;
      speeds[w] = SPEED_W'(q);
    end
    return speeds;
  endfunction

  task automatic queue_frame(input speed_set_t speeds);
    frame_bytes_due.push_back('{FRAME_HEADER, 1'b0});
    for (int w = 0; w < NUM_WHEELS; w++) begin
      frame_bytes_due.push_back('{speeds[w][15:8], 1'b0});
      frame_bytes_due.push_back('{speeds[w][7:0], 1'b0});
    end
    frame_bytes_due.push_back('{FRAME_FOOTER, 1'b1});
  endtask

  task automatic write_reg(input cfg_idx_t idx, input wheel_reg_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    // indexes past the spin gain are ignored
    if (idx < NUM_WHEELS) wheel_coeffs[idx[WHEEL_IDX_W-1:0]] = data;
    else if (idx == REG_SPIN_GAIN) spin_coeff = data[COEF_W-1:0];
  endtask

  task automatic program_coeffs(input coeff_set_t s);
    write_reg(REG_WHEEL0, s.w0);
    write_reg(REG_WHEEL1, s.w1);
    write_reg(REG_WHEEL2, s.w2);
    write_reg(REG_WHEEL3, s.w3);
    // junk in the upper half must not reach the spin gain
    write_reg(REG_SPIN_GAIN, {$urandom, s.spin});
    write_reg(cfg_idx_t'($urandom_range(REG_SPIN_GAIN + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  task automatic wait_frames_done();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_command(input vel_t vx, input vel_t vy, input vel_t om,
                              input bit typed, input speed_set_t typed_speeds);
    if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    vel_x_mm     <= vx;
    vel_y_mm     <= vy;
    angular_rate <= om;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_frame(typed ? typed_speeds : predict_wheel_speeds(vx, vy, om));
  endtask

  function automatic vel_t rand_vel();
    case ($urandom_range(0, 7))
      0: return VEL_MIN;
      1: return VEL_MAX;
      2: return vel_t'(int'($urandom_range(0, 2)) - 1);
      3, 4: return vel_t'(int'($urandom_range(0, 4000)) - 2000);
      default: return vel_t'($urandom);
    endcase
  endfunction

  // Mostly moderate gains so that speeds land inside int16, with extremes now and then.
  function automatic coef_t rand_coef(input int span);
    case ($urandom_range(0, 7))
      0: return coef_t'($urandom);
      1: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      2: return '0;
      default: return coef_t'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic coeff_set_t rand_coeff_set();
    coeff_set_t s;
    s.w0   = {rand_coef(1 << 26), rand_coef(1 << 26)};
    s.w1   = {rand_coef(1 << 26), rand_coef(1 << 26)};
    s.w2   = {rand_coef(1 << 26), rand_coef(1 << 26)};
    s.w3   = {rand_coef(1 << 26), rand_coef(1 << 26)};
    s.spin = rand_coef(1 << 26);
    return s;
  endfunction

  // Check output bytes and throttle the receiver.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("byte with no frame due", frame_byte, 8'h00);
        end else begin
          due_beat = frame_bytes_due.pop_front();
          if (frame_byte !== due_beat.data) begin
            report_mismatch("frame_byte", frame_byte, due_beat.data);
          end
          if (frame_last !== due_beat.last) begin
            report_mismatch("frame_last", {7'd0, frame_last}, {7'd0, due_beat.last});
          end
        end
        beats_seen++;
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (receiver_stall_pct != 0 && $urandom_range(1, 100) <= receiver_stall_pct) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int         current_set;
    cmd_row_t   row;
    speed_set_t typed_speeds;

    for (int w = 0; w < NUM_WHEELS; w++) wheel_coeffs[w] = '0;
    spin_coeff  = '0;
    current_set = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct    = 20;
    receiver_stall_pct = 20;
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.cfg_set != current_set) begin
        wait_frames_done();
        program_coeffs(DIRECTED_SETS[row.cfg_set]);
        current_set = row.cfg_set;
      end
      typed_speeds = {SPEED_W'(row.s3), SPEED_W'(row.s2), SPEED_W'(row.s1), SPEED_W'(row.s0)};
      send_command(vel_t'(row.vx), vel_t'(row.vy), vel_t'(row.om), row.typed != 0,
                   typed_speeds);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_frames_done();
      program_coeffs(rand_coeff_set());
      if (phase == RAND_PHASES - 1) begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end else begin
        sender_idle_pct    = 15 * $urandom_range(0, 3);
        receiver_stall_pct = 15 * $urandom_range(0, 3);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until the output has emptied
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_frames_done();
        send_command(rand_vel(), rand_vel(), rand_vel(), 1'b0, '0);
      end
    end

    wait_frames_done();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
hw/rtl/owfe_pkg.sv
hw/rtl/owfe_mul_stage.sv
hw/rtl/owfe_sum_stage.sv
hw/rtl/owfe_sat_stage.sv
hw/rtl/owfe_frame.sv
hw/rtl/omni_wheel_speed_frame_encoder.sv
dv/tb_omni_wheel_speed_frame_encoder.sv
